// ===== rtl/core/mlim_pkg.sv =====
// Shared constants and controller/datapath types for the multi-limb multiplier.
package mlim_pkg;

	// Operation codes carried by the op field of an input word.
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_MUL    = 2'd2;

	// Fixed field widths of the channels.
	localparam int OP_W      = 2;
	localparam int LIDX_W    = 5;
	localparam int LVAL_W    = 32;
	localparam int CNT_W     = 6;
	localparam int PIDX_W    = 6;
	localparam int RL_W      = 7;

	// Configuration port layout: one register on a 32-bit data port, word addressed.
	localparam int          CFG_ADDR_W       = 3;
	localparam int          CFG_DATA_W       = 32;
	localparam int          CFG_IDX_BIT      = 2;
	localparam logic        REG_RESULT_LIMBS = 1'b0;
	localparam logic [RL_W-1:0] RESULT_LIMBS_RST = 7'd64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load_a;
		logic              load_b;
		logic [LIDX_W-1:0] load_idx;
		logic              issue;
		logic              first_row;
		logic [CNT_W-1:0]  a_idx;
		logic [CNT_W-1:0]  b_idx;
		logic [RL_W-1:0]   p_idx;
		logic              carry_clr;
		logic              carry_wr;
		logic              emit_rd;
		logic              emit_ld;
		logic              emit_zero;
		logic [PIDX_W-1:0] emit_idx;
		logic              emit_last;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/mlim_cmd_if.sv =====
// Input channel: load and multiply words with valid/ready handshake.
interface mlim_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [mlim_pkg::OP_W-1:0]      op;
	logic [mlim_pkg::LIDX_W-1:0]    limb_index;
	logic [mlim_pkg::LVAL_W-1:0]    limb_value;
	logic [mlim_pkg::CNT_W-1:0]     a_count;
	logic [mlim_pkg::CNT_W-1:0]     b_count;

	modport source (output valid, op, limb_index, limb_value, a_count, b_count, input ready);
	modport sink (input valid, op, limb_index, limb_value, a_count, b_count, output ready);
endinterface

// ===== rtl/core/mlim_res_if.sv =====
// Output channel: product limbs with valid/ready handshake.
interface mlim_res_if;
	logic                           valid;
	logic                           ready;
	logic [mlim_pkg::PIDX_W-1:0]    product_index;
	logic [mlim_pkg::LVAL_W-1:0]    product_limb;
	logic                           last;

	modport source (output valid, product_index, product_limb, last, input ready);
	modport sink (input valid, product_index, product_limb, last, output ready);
endinterface

// ===== rtl/core/mlim_ctrl.sv =====
// Controller: sequences loads, the row-by-row multiply walk and the limb emission.
module mlim_ctrl #(
	parameter int MAX_OPERAND_LIMBS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [mlim_pkg::OP_W-1:0]     op,
	input  logic [mlim_pkg::LIDX_W-1:0]   limb_index,
	input  logic [mlim_pkg::CNT_W-1:0]    a_count,
	input  logic [mlim_pkg::CNT_W-1:0]    b_count,
	input  logic [mlim_pkg::RL_W-1:0]     result_limbs,
	input  mlim_pkg::dp_stat_t            stat,
	output mlim_pkg::dp_cmd_t             ctl
);

	localparam logic [mlim_pkg::CNT_W-1:0] MAX_CNT = mlim_pkg::CNT_W'(MAX_OPERAND_LIMBS);
	localparam logic [mlim_pkg::RL_W-1:0]  MAX_RES = mlim_pkg::RL_W'(2 * MAX_OPERAND_LIMBS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_DRAIN,
		S_EMIT_RD,
		S_EMIT_WAIT
	} state_t;

	state_t                        state_q;
	logic [mlim_pkg::CNT_W-1:0]    i_q;
	logic [mlim_pkg::CNT_W-1:0]    j_q;
	logic [mlim_pkg::CNT_W-1:0]    ac_q;
	logic [mlim_pkg::CNT_W-1:0]    bc_q;
	logic [mlim_pkg::RL_W-1:0]     rl_q;
	logic [mlim_pkg::RL_W-1:0]     lim_q;
	logic [mlim_pkg::RL_W-1:0]     k_q;

	logic                          accept;
	logic                          load_ok;
	logic [mlim_pkg::CNT_W-1:0]    ac_sat;
	logic [mlim_pkg::CNT_W-1:0]    bc_sat;
	logic [mlim_pkg::RL_W-1:0]     rl_sat;
	logic [mlim_pkg::RL_W-1:0]     lim_new;
	logic                          row_last;
	logic                          col_last;
	logic                          limb_last;
	logic                          start_mul;

	// Clamp the counts and the result length the way the register map defines them.
	always_comb begin
		ac_sat = (a_count > MAX_CNT) ? MAX_CNT : a_count;
		bc_sat = (b_count > MAX_CNT) ? MAX_CNT : b_count;
		if (result_limbs == '0) begin
			rl_sat = mlim_pkg::RL_W'(1);
		end else if (result_limbs > MAX_RES) begin
			rl_sat = MAX_RES;
		end else begin
			rl_sat = result_limbs;
		end
		// Product limbs at or above ac+bc are never written and read as zero.
		if (ac_sat == '0 || bc_sat == '0) begin
			lim_new = '0;
		end else begin
			lim_new = {1'b0, ac_sat} + {1'b0, bc_sat};
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign load_ok   = {1'b0, limb_index} < MAX_CNT;
	assign start_mul = accept && (op == mlim_pkg::OP_MUL);
	assign row_last  = (i_q + 6'd1) == ac_q;
	assign col_last  = (j_q + 6'd1) == bc_q;
	assign limb_last = (k_q + 7'd1) == rl_q;

	// Datapath commands decoded from the state.
	always_comb begin
		ctl           = '0;
		ctl.load_idx  = limb_index;
		ctl.load_a    = accept && (op == mlim_pkg::OP_LOAD_A) && load_ok;
		ctl.load_b    = accept && (op == mlim_pkg::OP_LOAD_B) && load_ok;
		ctl.first_row = (i_q == '0);
		ctl.a_idx     = i_q;
		ctl.b_idx     = j_q;
		ctl.carry_clr = start_mul;
		ctl.emit_idx  = k_q[mlim_pkg::PIDX_W-1:0];
		ctl.emit_zero = (k_q >= lim_q);
		ctl.emit_last = limb_last;
		case (state_q)
			S_ISSUE: begin
				ctl.issue = 1'b1;
				ctl.p_idx = {1'b0, i_q} + {1'b0, j_q};
			end
			S_DRAIN: begin
				ctl.p_idx     = {1'b0, i_q} + {1'b0, bc_q};
				ctl.carry_wr  = !stat.pipe_busy;
				ctl.carry_clr = !stat.pipe_busy;
			end
			S_EMIT_RD: begin
				ctl.emit_rd = 1'b1;
				ctl.p_idx   = k_q;
			end
			S_EMIT_WAIT: begin
				ctl.emit_ld = stat.out_free;
			end
			default: begin
			end
		endcase
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ac_q    <= '0;
			bc_q    <= '0;
			rl_q    <= '0;
			lim_q   <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_mul) begin
						ac_q  <= ac_sat;
						bc_q  <= bc_sat;
						rl_q  <= rl_sat;
						lim_q <= lim_new;
						i_q   <= '0;
						j_q   <= '0;
						k_q   <= '0;
						state_q <= (lim_new == '0) ? S_EMIT_RD : S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (col_last) begin
						j_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + 6'd1;
					end
				end
				S_DRAIN: begin
					// The row's carry is written once the last partial sum has landed.
					if (!stat.pipe_busy) begin
						i_q     <= i_q + 6'd1;
						state_q <= row_last ? S_EMIT_RD : S_ISSUE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (stat.out_free) begin
						k_q     <= k_q + 7'd1;
						state_q <= limb_last ? S_IDLE : S_EMIT_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/mlim_dp.sv =====
// Datapath: operand and product memories, multiply-accumulate pipeline, output register.
module mlim_dp #(
	parameter int MAX_OPERAND_LIMBS = 32,
	parameter int LIMB_BITS         = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlim_pkg::dp_cmd_t             ctl,
	output mlim_pkg::dp_stat_t            stat,
	input  logic [mlim_pkg::LVAL_W-1:0]   limb_value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [mlim_pkg::PIDX_W-1:0]   product_index,
	output logic [mlim_pkg::LVAL_W-1:0]   product_limb,
	output logic                          last
);

	localparam int AW = (MAX_OPERAND_LIMBS > 1) ? $clog2(MAX_OPERAND_LIMBS) : 1;
	localparam int PD = 2 * MAX_OPERAND_LIMBS;
	localparam int PW = $clog2(PD);
	localparam int LB = LIMB_BITS;

	logic [LB-1:0]   a_mem [MAX_OPERAND_LIMBS];
	logic [LB-1:0]   b_mem [MAX_OPERAND_LIMBS];
	logic [LB-1:0]   p_mem [PD];

	logic [LB-1:0]   a_rd_s1;
	logic [LB-1:0]   b_rd_s1;
	logic [LB-1:0]   p_rd_s1;
	logic [PW-1:0]   widx_s1;
	logic            v_s1;
	logic [2*LB-1:0] prod_s2;
	logic [LB-1:0]   pacc_s2;
	logic [PW-1:0]   widx_s2;
	logic            v_s2;
	logic [LB-1:0]   carry_q;

	logic [2*LB-1:0] mul_prod;
	logic [LB-1:0]   addend;
	logic [2*LB-1:0] sum;
	logic            p_we;
	logic [PW-1:0]   p_waddr;
	logic [LB-1:0]   p_wdata;

	logic                          out_valid_q;
	logic [mlim_pkg::PIDX_W-1:0]   product_index_q;
	logic [mlim_pkg::LVAL_W-1:0]   product_limb_q;
	logic                          last_q;

	// Operand stores: written by load words, read one limb each per issued pair.
	always_ff @(posedge clk) begin
		if (ctl.load_a) begin
			a_mem[ctl.load_idx[AW-1:0]] <= limb_value[LB-1:0];
		end
		if (ctl.load_b) begin
			b_mem[ctl.load_idx[AW-1:0]] <= limb_value[LB-1:0];
		end
		if (ctl.issue) begin
			a_rd_s1 <= a_mem[ctl.a_idx[AW-1:0]];
			b_rd_s1 <= b_mem[ctl.b_idx[AW-1:0]];
			widx_s1 <= ctl.p_idx[PW-1:0];
		end
	end

	// Product store: one write port shared by the accumulate stage and the row carry.
	assign p_we    = v_s2 || ctl.carry_wr;
	assign p_waddr = v_s2 ? widx_s2 : ctl.p_idx[PW-1:0];
	assign p_wdata = v_s2 ? sum[LB-1:0] : carry_q;

	always_ff @(posedge clk) begin
		if (p_we) begin
			p_mem[p_waddr] <= p_wdata;
		end
		if (ctl.issue || ctl.emit_rd) begin
			p_rd_s1 <= p_mem[ctl.p_idx[PW-1:0]];
		end
	end

	// Multiply stage.
	assign mul_prod = a_rd_s1 * b_rd_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= mul_prod;
		pacc_s2 <= p_rd_s1;
		widx_s2 <= widx_s1;
	end

	// Accumulate stage: the first row starts from a cleared product.
	assign addend = ctl.first_row ? '0 : pacc_s2;
	assign sum    = prod_s2 + {{LB{1'b0}}, addend} + {{LB{1'b0}}, carry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			carry_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			if (ctl.carry_clr) begin
				carry_q <= '0;
			end else if (v_s2) begin
				carry_q <= sum[2*LB-1:LB];
			end
		end
	end

	// Output register holding one product word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_ld) begin
			product_index_q <= ctl.emit_idx;
			product_limb_q  <= ctl.emit_zero ? '0 : mlim_pkg::LVAL_W'(p_rd_s1);
			last_q          <= ctl.emit_last;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2;
	assign stat.out_free  = !out_valid_q || res_ready;

	assign res_valid     = out_valid_q;
	assign product_index = product_index_q;
	assign product_limb  = product_limb_q;
	assign last          = last_q;

endmodule

// ===== rtl/core/multi_limb_integer_multiplier.sv =====
// A load word is accepted in the idle state and leaves the block ready for the next word.
// A multiply walks a_count rows of b_count limb pairs through one shared multiplier,
// each row being pair issue, a two-stage drain and the carry write, then emits
// result_limbs words, each a product memory read and an output register load once free.
// No new input word is taken until the last word is loaded for output; no rows are
// walked when either count is zero. Reset: asynchronous, active low;
// control clears, result_limbs returns to 64, stores keep junk.
module multi_limb_integer_multiplier #(
	parameter int MAX_OPERAND_LIMBS = 32,
	parameter int LIMB_BITS         = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mlim_cmd_if.sink                           cmd,
	mlim_res_if.source                         res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mlim_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [mlim_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [mlim_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready
);

	logic [mlim_pkg::RL_W-1:0] result_limbs_q;
	logic                      reg_sel;
	mlim_pkg::dp_cmd_t         ctl;
	mlim_pkg::dp_stat_t        stat;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_sel = (paddr[mlim_pkg::CFG_IDX_BIT] == mlim_pkg::REG_RESULT_LIMBS);
	assign prdata  = reg_sel ? mlim_pkg::CFG_DATA_W'(result_limbs_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_limbs_q <= mlim_pkg::RESULT_LIMBS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			result_limbs_q <= pwdata[mlim_pkg::RL_W-1:0];
		end
	end

	mlim_ctrl #(
		.MAX_OPERAND_LIMBS(MAX_OPERAND_LIMBS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd.valid),
		.cmd_ready   (cmd.ready),
		.op          (cmd.op),
		.limb_index  (cmd.limb_index),
		.a_count     (cmd.a_count),
		.b_count     (cmd.b_count),
		.result_limbs(result_limbs_q),
		.stat        (stat),
		.ctl         (ctl)
	);

	mlim_dp #(
		.MAX_OPERAND_LIMBS(MAX_OPERAND_LIMBS),
		.LIMB_BITS        (LIMB_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.limb_value   (cmd.limb_value),
		.res_valid    (res.valid),
		.res_ready    (res.ready),
		.product_index(res.product_index),
		.product_limb (res.product_limb),
		.last         (res.last)
	);

endmodule

// ===== rtl/core/mlim_check.sv =====
// Port-level checks for the multiplier and the bind that attaches them.
module mlim_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic [mlim_pkg::OP_W-1:0]         cmd_op,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [mlim_pkg::PIDX_W-1:0]       res_product_index,
	input logic [mlim_pkg::LVAL_W-1:0]       res_product_limb,
	input logic                              res_last
);

	// A waiting word holds still until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_product_index)
			&& $stable(res_product_limb) && $stable(res_last))
		else $error("product word changed while stalled");

	// While a run is still being emitted no new input word is taken.
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !cmd_ready)
		else $error("input ready in the middle of a product run");

	// A multiply occupies the block for at least the following cycle.
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_op == mlim_pkg::OP_MUL |=> !cmd_ready)
		else $error("input ready right after a multiply word");

	// Loads and unused codes finish at once.
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_op != mlim_pkg::OP_MUL |=> cmd_ready)
		else $error("input not ready after a load word");

endmodule

bind multi_limb_integer_multiplier mlim_check u_mlim_check (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_op           (cmd.op),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_product_index(res.product_index),
	.res_product_limb (res.product_limb),
	.res_last         (res.last)
);
